[rtl/local_window_autocorrelation_core_defines.svh]
// Assertion macros for the local window autocorrelation core.
// Used by modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef LOCAL_WINDOW_AUTOCORRELATION_CORE_DEFINES_SVH
`define LOCAL_WINDOW_AUTOCORRELATION_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define LWAC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LWAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/lwac_pkg.sv]
// Shared types, constants and a small helper function of the window autocorrelation core.
// No dependencies.
`timescale 1ns / 1ps

package lwac_pkg;

  localparam int unsigned MAX_WINDOW = 15;
  localparam int unsigned W_W        = 4;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned SUM_W      = 25;
  localparam int unsigned SQ_W       = 39;
  localparam int unsigned AD_W       = 41;
  localparam int unsigned EDGE_W     = 23;
  localparam int unsigned WIDE_W     = 72;
  localparam int unsigned MB_W       = 32;
  localparam int unsigned QUO_W      = 11;
  localparam int unsigned RES_W      = 9;

  localparam logic [1:0]     REG_WINDOW_SIZE = 2'd0;
  localparam logic [W_W-1:0] WINDOW_RESET    = 4'd3;
  localparam logic [W_W-1:0] WINDOW_MIN      = 4'd2;

  typedef struct packed {
    logic [W_W-1:0]           w;
    logic signed [SUM_W-1:0]  s;
    logic [SQ_W-1:0]          q;
    logic signed [AD_W-1:0]   ad;
    logic signed [EDGE_W-1:0] e;
  } win_sums_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_e;

  typedef enum logic [2:0] {
    OP_SS    = 3'd0,
    OP_NQ    = 3'd1,
    OP_DEN   = 3'd2,
    OP_T3    = 3'd3,
    OP_T4    = 3'd4,
    OP_T5    = 3'd5,
    OP_T6    = 3'd6,
    OP_SCALE = 3'd7
  } mul_op_e;

  function automatic logic [11:0] w_cube(input logic [W_W-1:0] w);
    logic [11:0] r;
    r = 12'(w) * 12'(w) * 12'(w);
    return r;
  endfunction

endpackage

[rtl/lwac_front.sv]
// Front end: takes cells, keeps row delay line and per-window running sums.
// Depends on lwac_pkg; hands finished window sums to the queue.
`timescale 1ns / 1ps

module lwac_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clr_i,
  input  logic [lwac_pkg::W_W-1:0]             w_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [lwac_pkg::CELL_W-1:0]   cell_value_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output lwac_pkg::win_sums_t                  q_data_o
);

  logic signed [lwac_pkg::CELL_W-1:0] dly_q [lwac_pkg::MAX_WINDOW];
  logic signed [lwac_pkg::CELL_W-1:0] prev_q;
  logic [lwac_pkg::W_W-1:0] col_q, col_d, row_q, row_d;
  logic col_last, row_last, acc_in, stall;

  logic                  s1_valid_q, s1_valid_d, s1_last_q;
  logic signed [15:0]    s1_cell_q;
  logic [30:0]           s1_sq_q;
  logic signed [32:0]    s1_ad_q;
  logic signed [18:0]    s1_edge_q;
  logic signed [31:0]    ph, pv;
  logic signed [18:0]    edge_c, cext;

  logic signed [lwac_pkg::SUM_W-1:0]  sum_q, sum_n;
  logic [lwac_pkg::SQ_W-1:0]          sq_q, sq_n;
  logic signed [lwac_pkg::AD_W-1:0]   ad_q, ad_n;
  logic signed [lwac_pkg::EDGE_W-1:0] e_q, e_n;

  always_comb begin
    col_last = (col_q == w_i - 4'd1);
    row_last = (row_q == w_i - 4'd1);
    stall    = s1_valid_q & s1_last_q & q_full_i;
    full     = stall;
    acc_in   = push & ~full;
    q_push_o = s1_valid_q & s1_last_q & ~q_full_i;
    s1_valid_d = acc_in | stall;
    ph = (col_q != '0) ? cell_value_i * prev_q : 32'sd0;
    pv = (row_q != '0) ? cell_value_i * dly_q[col_q] : 32'sd0;
    cext = 19'(cell_value_i);
    edge_c = ((col_q == '0) ? cext : 19'sd0) + (col_last ? cext : 19'sd0)
           + ((row_q == '0) ? cext : 19'sd0) + (row_last ? cext : 19'sd0);
    col_d = col_q;
    row_d = row_q;
    if (acc_in) begin
      if (!col_last) begin
        col_d = col_q + 4'd1;
      end else begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 4'd1;
      end
    end
    sum_n = sum_q + lwac_pkg::SUM_W'(s1_cell_q);
    sq_n  = sq_q + lwac_pkg::SQ_W'(s1_sq_q);
    ad_n  = ad_q + lwac_pkg::AD_W'(s1_ad_q);
    e_n   = e_q + lwac_pkg::EDGE_W'(s1_edge_q);
    q_data_o.w  = w_i;
    q_data_o.s  = sum_n;
    q_data_o.q  = sq_n;
    q_data_o.ad = ad_n;
    q_data_o.e  = e_n;
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      dly_q[col_q] <= cell_value_i;
      prev_q       <= cell_value_i;
      s1_cell_q    <= cell_value_i;
      s1_sq_q      <= 31'(cell_value_i * cell_value_i);
      s1_ad_q      <= 33'(ph) + 33'(pv);
      s1_edge_q    <= edge_c;
      s1_last_q    <= col_last & row_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      sq_q       <= '0;
      ad_q       <= '0;
      e_q        <= '0;
    end else if (clr_i) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      sq_q       <= '0;
      ad_q       <= '0;
      e_q        <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (s1_valid_q && !stall) begin
        if (s1_last_q) begin
          sum_q <= '0;
          sq_q  <= '0;
          ad_q  <= '0;
          e_q   <= '0;
        end else begin
          sum_q <= sum_n;
          sq_q  <= sq_n;
          ad_q  <= ad_n;
          e_q   <= e_n;
        end
      end
    end
  end

endmodule

[rtl/lwac_queue.sv]
// Two-entry queue of finished window sums between front and back end.
// Depends on lwac_pkg.
`timescale 1ns / 1ps

module lwac_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lwac_pkg::win_sums_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lwac_pkg::win_sums_t data_o
);

  lwac_pkg::win_sums_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

[rtl/lwac_back.sv]
// Back end: shift-add multiplier and restoring divider evaluate one window.
// Depends on lwac_pkg and the assertion macro header; holds the result register.
`timescale 1ns / 1ps
`include "local_window_autocorrelation_core_defines.svh"

module lwac_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  input  lwac_pkg::win_sums_t                 q_data_i,
  output logic                                q_pop_o,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lwac_pkg::RES_W-1:0]   autocorr_percent_o,
  output logic                                zero_variance_o
);

  localparam int unsigned WW = lwac_pkg::WIDE_W;

  lwac_pkg::back_state_e st_q, st_d;
  lwac_pkg::mul_op_e     op_q;
  lwac_pkg::win_sums_t   win_q;

  logic [WW-1:0] a_q, acc_q, acc_d, addend;
  logic [lwac_pkg::MB_W-1:0] b_q;
  logic [4:0] mcnt_q;
  logic [3:0] dcnt_q;
  logic [WW-1:0] s2_q, nq_q, den_q, t3_q, t4_q, t5_q, t6_q, mag_q, rem_q, dsh_q;
  logic signed [WW-1:0] num;
  logic [WW-1:0] a_ld;
  logic [lwac_pkg::MB_W-1:0] b_ld;
  logic [lwac_pkg::QUO_W-1:0] quo_q;
  logic neg_q, zv_q, out_valid_q, slot_free;
  logic [lwac_pkg::QUO_W-1:0] clamp;
  logic [lwac_pkg::RES_W-1:0] res;
  logic [lwac_pkg::MB_W-1:0] k32;

  assign empty   = ~out_valid_q;
  assign q_pop_o = (st_q == lwac_pkg::ST_IDLE) & ~q_empty_i;
  assign slot_free = ~out_valid_q | pop;
  assign k32 = lwac_pkg::MB_W'({win_q.w - 4'd1, 1'b0});

  always_comb begin
    unique case (op_q)
      lwac_pkg::OP_SS: begin
        a_ld = WW'(win_q.s);
        b_ld = lwac_pkg::MB_W'(win_q.s);
      end
      lwac_pkg::OP_NQ: begin
        a_ld = WW'(win_q.q);
        b_ld = lwac_pkg::MB_W'(16'(win_q.w) * 16'(win_q.w));
      end
      lwac_pkg::OP_DEN: begin
        a_ld = nq_q - s2_q;
        b_ld = k32;
      end
      lwac_pkg::OP_T3: begin
        a_ld = (WW'(win_q.s) << 2) - WW'(win_q.e);
        b_ld = lwac_pkg::MB_W'(win_q.s);
      end
      lwac_pkg::OP_T4: begin
        a_ld = t3_q;
        b_ld = lwac_pkg::MB_W'(win_q.w);
      end
      lwac_pkg::OP_T5: begin
        a_ld = WW'(win_q.ad);
        b_ld = lwac_pkg::MB_W'(lwac_pkg::w_cube(win_q.w));
      end
      lwac_pkg::OP_T6: begin
        a_ld = s2_q;
        b_ld = k32;
      end
      lwac_pkg::OP_SCALE: begin
        a_ld = mag_q;
        b_ld = 32'd100;
      end
      default: begin
        a_ld = '0;
        b_ld = '0;
      end
    endcase
  end

  always_comb begin
    if (!b_q[0]) addend = '0;
    else if (mcnt_q == 5'd31) addend = ~a_q + WW'(1);
    else addend = a_q;
    acc_d = acc_q + addend;
    num = $signed(t5_q) - $signed(t4_q) + $signed(t6_q);
    if (neg_q) clamp = (quo_q > 11'd256) ? 11'd256 : quo_q;
    else clamp = (quo_q > 11'd255) ? 11'd255 : quo_q;
    res = neg_q ? 9'(~clamp + 11'd1) : 9'(clamp);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      lwac_pkg::ST_IDLE: if (!q_empty_i) st_d = lwac_pkg::ST_LOAD;
      lwac_pkg::ST_LOAD: st_d = lwac_pkg::ST_MUL;
      lwac_pkg::ST_MUL: begin
        if (mcnt_q == 5'd31) begin
          if (op_q == lwac_pkg::OP_T6) st_d = lwac_pkg::ST_FIX;
          else if (op_q == lwac_pkg::OP_SCALE) st_d = lwac_pkg::ST_DIV;
          else st_d = lwac_pkg::ST_LOAD;
        end
      end
      lwac_pkg::ST_FIX: st_d = (den_q == '0) ? lwac_pkg::ST_OUT : lwac_pkg::ST_LOAD;
      lwac_pkg::ST_DIV: if (dcnt_q == '0) st_d = lwac_pkg::ST_OUT;
      lwac_pkg::ST_OUT: if (slot_free) st_d = lwac_pkg::ST_IDLE;
      default: st_d = lwac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      lwac_pkg::ST_IDLE: begin
        win_q <= q_data_i;
        zv_q  <= 1'b0;
      end
      lwac_pkg::ST_LOAD: begin
        a_q    <= a_ld;
        b_q    <= b_ld;
        acc_q  <= '0;
        mcnt_q <= '0;
      end
      lwac_pkg::ST_MUL: begin
        acc_q  <= acc_d;
        a_q    <= {a_q[WW-2:0], 1'b0};
        b_q    <= {1'b0, b_q[lwac_pkg::MB_W-1:1]};
        mcnt_q <= mcnt_q + 5'd1;
        if (mcnt_q == 5'd31) begin
          unique case (op_q)
            lwac_pkg::OP_SS:  s2_q  <= acc_d;
            lwac_pkg::OP_NQ:  nq_q  <= acc_d;
            lwac_pkg::OP_DEN: den_q <= acc_d;
            lwac_pkg::OP_T3:  t3_q  <= acc_d;
            lwac_pkg::OP_T4:  t4_q  <= acc_d;
            lwac_pkg::OP_T5:  t5_q  <= acc_d;
            lwac_pkg::OP_T6:  t6_q  <= acc_d;
            lwac_pkg::OP_SCALE: begin
              rem_q  <= acc_d;
              dsh_q  <= {den_q[WW-11:0], 10'b0};
              dcnt_q <= 4'd10;
              quo_q  <= '0;
            end
            default: ;
          endcase
        end
      end
      lwac_pkg::ST_FIX: begin
        neg_q <= num[WW-1];
        mag_q <= num[WW-1] ? WW'(-num) : WW'(num);
        zv_q  <= (den_q == '0);
      end
      lwac_pkg::ST_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[lwac_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[lwac_pkg::QUO_W-2:0], 1'b0};
        end
        dsh_q  <= {1'b0, dsh_q[WW-1:1]};
        dcnt_q <= dcnt_q - 4'd1;
      end
      lwac_pkg::ST_OUT: begin
        if (slot_free) begin
          autocorr_percent_o <= zv_q ? 9'sd100 : $signed(res);
          zero_variance_o    <= zv_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lwac_pkg::ST_IDLE;
      op_q        <= lwac_pkg::OP_SS;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == lwac_pkg::ST_IDLE) begin
        op_q <= lwac_pkg::OP_SS;
      end else if (st_q == lwac_pkg::ST_MUL && mcnt_q == 5'd31
                   && op_q != lwac_pkg::OP_SCALE) begin
        op_q <= lwac_pkg::mul_op_e'(op_q + 3'd1);
      end
      if (st_q == lwac_pkg::ST_OUT && slot_free) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  `LWAC_ASSERT(a_div_nonzero, (st_q != lwac_pkg::ST_DIV) || (den_q != '0), "divide by zero")
  `LWAC_ASSERT_NEXT(a_out_hold, (st_q == lwac_pkg::ST_OUT) && out_valid_q && !pop, st_q == lwac_pkg::ST_OUT, "result slot overwritten")
  `LWAC_ASSERT_NEXT(a_start, (st_q == lwac_pkg::ST_IDLE) && !q_empty_i, (st_q == lwac_pkg::ST_LOAD) && (op_q == lwac_pkg::OP_SS), "window start lost")
  `LWAC_ASSERT_NEXT(a_pop_idle, q_pop_o, st_q != lwac_pkg::ST_IDLE, "queue popped twice")

endmodule

[rtl/local_window_autocorrelation_core.sv]
// Top level of the local window autocorrelation core: config register and glue.
// Depends on lwac_pkg, lwac_front, lwac_queue and lwac_back.
`timescale 1ns / 1ps
//
// Cells of a square window enter row-major on push/full, one per cycle while
// full is low. After the last cell of a window one result item (percent value
// and zero-variance flag) appears on the result side; it is shown while empty
// is low and taken with pop.
// The front end accumulates one cell per cycle while full is low. A two-entry
// queue holds finished window sums; the back end evaluates a window with eight
// 32-step shift-add multiplications and an 11-step restoring division, and
// skips the scaling multiplication and the division when the variance is zero.
// The front end takes cells of the next window while the back end evaluates.
// A result waiting on pop stalls the back end after its next evaluation; the
// queue then fills and full rises.
// Reset sets window_size to 3 and empties all stages. Writing window_size
// (byte address 0) restarts the current window; values below 2 read as 2.

module local_window_autocorrelation_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lwac_pkg::CELL_W-1:0]  cell_value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lwac_pkg::RES_W-1:0]   autocorr_percent_o,
  output logic                                zero_variance_o
);

  logic [lwac_pkg::W_W-1:0] w_q;
  logic                     cfg_wr;
  logic                     q_push, q_full, q_pop, q_empty;
  lwac_pkg::win_sums_t      q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr == lwac_pkg::REG_WINDOW_SIZE) ? 32'(w_q) : 32'd0;
  assign cfg_wr = psel & penable & pwrite & (paddr == lwac_pkg::REG_WINDOW_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= lwac_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      w_q <= (pwdata[3:0] < lwac_pkg::WINDOW_MIN) ? lwac_pkg::WINDOW_MIN : pwdata[3:0];
    end
  end

  lwac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (cfg_wr),
    .w_i          (w_q),
    .push         (push),
    .full         (full),
    .cell_value_i (cell_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  lwac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  lwac_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_data_i           (q_out),
    .q_pop_o            (q_pop),
    .empty              (empty),
    .pop                (pop),
    .autocorr_percent_o (autocorr_percent_o),
    .zero_variance_o    (zero_variance_o)
  );

endmodule
